[rtl/tlpf_pkg.sv]
// Package: shared types and constants of the topic line parser filter.
package tlpf_pkg;

  localparam int unsigned MAX_TOPICS_DEF      = 8;
  localparam int unsigned TOPIC_MAX_LEN_DEF   = 31;
  localparam int unsigned LINE_MAX_LEN_DEF    = 511;
  localparam int unsigned MESSAGE_MAX_LEN_DEF = 256;

  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_BSL   = 8'h5c;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_U     = 8'h55;
  localparam logic [7:0] CHAR_B     = 8'h42;

  localparam logic CMD_SERIAL = 1'b0;
  localparam logic CMD_TOPIC  = 1'b1;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_NO_SUB    = 2'd1,
    ST_NOT_PUB   = 2'd2,
    ST_NO_COLON  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       matched;
    logic [2:0] subscriber;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Broadcast from the parser to every cell.
  typedef struct packed {
    logic       load_we;
    logic       load_commit;
    logic       cmp_en;
    logic       match_set;
    logic [7:0] ch;
  } cell_ctl_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CHAR_P;
      2'd1:    c = CHAR_U;
      2'd2:    c = CHAR_B;
      default: c = CHAR_COLON;
    endcase
    return c;
  endfunction

endpackage

[rtl/tlpf_if.sv]
// Interfaces: input and output channels of the topic line parser filter.
interface tlpf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte_in;
  logic       topic_end;
  modport source (output valid, cmd, byte_in, topic_end, input ready);
  modport sink   (input valid, cmd, byte_in, topic_end, output ready);
endinterface

interface tlpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       matched;
  logic [2:0] subscriber;
  logic [1:0] status;
  logic       last;
  modport source (output valid, data_byte, matched, subscriber, status, last, input ready);
  modport sink   (input valid, data_byte, matched, subscriber, status, last, output ready);
endinterface

[rtl/tlpf_cell.sv]
// Cell: one subscription entry with its topic, length and running match bit.
module tlpf_cell
  import tlpf_pkg::*;
#(
  parameter int unsigned TopicMaxLen = TOPIC_MAX_LEN_DEF,
  localparam int unsigned LenW = $clog2(TopicMaxLen + 1),
  localparam int unsigned IdxW = (TopicMaxLen > 1) ? $clog2(TopicMaxLen) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic            sel_i,
  input  logic [LenW-1:0] load_pos_i,
  input  logic [LenW-1:0] field_pos_i,
  input  logic            hit_i,
  output logic            hit_o,
  output logic            first_o
);

  logic [7:0]      topic_q [TopicMaxLen];
  logic [LenW-1:0] len_q;
  logic            valid_q;
  logic            match_q;
  logic            mine;
  logic            miss;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;

  assign rd_idx = IdxW'(field_pos_i);
  assign wr_idx = IdxW'(load_pos_i);
  assign miss   = (field_pos_i >= len_q) || (topic_q[rd_idx] != ctl_i.ch);
  assign mine   = valid_q && match_q && (len_q == field_pos_i);
  assign first_o = mine && !hit_i;
  assign hit_o   = mine || hit_i;

  always_ff @(posedge clk_i) begin
    if (sel_i && ctl_i.load_we) begin
      topic_q[wr_idx] <= ctl_i.ch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      valid_q <= 1'b0;
      match_q <= 1'b1;
    end else begin
      // Count the character that arrives with the commit.
      if (sel_i && ctl_i.load_commit) begin
        len_q   <= ctl_i.load_we ? load_pos_i + LenW'(1) : load_pos_i;
        valid_q <= 1'b1;
      end
      if (ctl_i.match_set) begin
        match_q <= 1'b1;
      end else if (ctl_i.cmp_en && miss) begin
        match_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/tlpf_out_fifo.sv]
// Output queue: takes up to two items a cycle, hands out one.
module tlpf_out_fifo
  import tlpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push0_i,
  input  logic      push1_i,
  input  out_item_t item0_i,
  input  out_item_t item1_i,
  output logic      room_o,
  tlpf_out_if.source out_o
);

  out_item_t  mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] wr1;
  logic [1:0] npush;
  out_item_t  head;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q <= 3'd2;
  assign wr1    = push0_i ? wr_q + 2'd1 : wr_q;
  assign npush  = {1'b0, push0_i} + {1'b0, push1_i};
  assign head   = mem_q[rd_q];

  assign out_o.valid      = cnt_q != 3'd0;
  assign out_o.data_byte  = head.data_byte;
  assign out_o.matched    = head.matched;
  assign out_o.subscriber = head.subscriber;
  assign out_o.status     = head.status;
  assign out_o.last       = head.last;

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= item0_i;
    if (push1_i) mem_q[wr1]  <= item1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + npush;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, npush} - {2'b0, pop};
    end
  end

endmodule

[rtl/topic_line_parser_filter.sv]
// Top level: line parser, subscription cell chain and output queue.
//
// channel  dir  fields                                       accepted when
// in_i     in   cmd, byte_in, topic_end                      valid && ready
// out_o    out  data_byte, matched, subscriber, status, last valid && ready
//
// One item per cycle while ready; all cells compare each topic byte together.
// A newline item may yield two results; the four-entry output queue takes
// new items while it holds two or fewer, so out_o stalls stop in_i at three
// entries. Reset is asynchronous; the table starts empty, no clearing pass.
module topic_line_parser_filter
  import tlpf_pkg::*;
#(
  parameter int unsigned MaxTopics     = MAX_TOPICS_DEF,
  parameter int unsigned TopicMaxLen   = TOPIC_MAX_LEN_DEF,
  parameter int unsigned LineMaxLen    = LINE_MAX_LEN_DEF,
  parameter int unsigned MessageMaxLen = MESSAGE_MAX_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlpf_in_if.sink    in_i,
  tlpf_out_if.source out_o
);

  localparam int unsigned LenW  = $clog2(TopicMaxLen + 1);
  localparam int unsigned SubW  = $clog2(MaxTopics + 1);
  localparam int unsigned LineW = $clog2(LineMaxLen + 1);
  localparam int unsigned MsgW  = $clog2(MessageMaxLen);
  localparam int unsigned FldW  = (LenW > 3) ? LenW : 3;

  typedef enum logic [1:0] {PH_PREFIX, PH_TOPIC, PH_MSG, PH_BAD} phase_e;

  phase_e           phase_q, phase_d;
  logic [SubW-1:0]  sub_cnt_q, sub_cnt_d;
  logic [LenW-1:0]  load_pos_q, load_pos_d;
  logic             load_stop_q, load_stop_d;
  logic [LineW-1:0] line_cnt_q, line_cnt_d;
  logic [FldW-1:0]  fld_q, fld_d;
  logic             pend_q, pend_d;
  logic [MsgW-1:0]  msg_cnt_q, msg_cnt_d;
  logic             hit_q, hit_d;
  logic [2:0]       sub_idx_q, sub_idx_d;
  logic             ended_q, ended_d;

  cell_ctl_t        ctl;
  logic [MaxTopics:0]   hit_chain;
  logic [MaxTopics-1:0] first;
  logic [2:0]       first_idx;
  logic             acc, room, push0, push1, out_hit;
  out_item_t        item0, item1;
  logic [7:0]       b;

  assign acc  = in_i.valid && in_i.ready;
  assign b    = in_i.byte_in;
  assign in_i.ready = room;
  assign out_hit = (phase_q == PH_MSG) && hit_q;

  assign hit_chain[0] = 1'b0;
  for (genvar g = 0; g < MaxTopics; g++) begin : g_cell
    tlpf_cell #(.TopicMaxLen(TopicMaxLen)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sel_i      (sub_cnt_q == SubW'(g)),
      .load_pos_i (load_pos_q),
      .field_pos_i(LenW'(fld_q)),
      .hit_i      (hit_chain[g]),
      .hit_o      (hit_chain[g+1]),
      .first_o    (first[g])
    );
  end

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < MaxTopics; i++) begin
      if (first[i]) first_idx = 3'(i);
    end
  end

  always_comb begin
    phase_d     = phase_q;
    sub_cnt_d   = sub_cnt_q;
    load_pos_d  = load_pos_q;
    load_stop_d = load_stop_q;
    line_cnt_d  = line_cnt_q;
    fld_d       = fld_q;
    pend_d      = pend_q;
    msg_cnt_d   = msg_cnt_q;
    hit_d       = hit_q;
    sub_idx_d   = sub_idx_q;
    ended_d     = ended_q;
    ctl         = '0;
    ctl.ch      = b;
    push0       = 1'b0;
    push1       = 1'b0;
    item0       = '{data_byte: CHAR_BSL, matched: out_hit,
                    subscriber: out_hit ? sub_idx_q : 3'd0,
                    status: ST_DELIVERED, last: 1'b0};
    item1       = item0;

    if (acc && in_i.cmd == CMD_TOPIC) begin
      if (sub_cnt_q < SubW'(MaxTopics)) begin
        if (!load_stop_q) begin
          if (b == 8'd0) begin
            load_stop_d = 1'b1;
          end else if (load_pos_q < LenW'(TopicMaxLen)) begin
            ctl.load_we = 1'b1;
            load_pos_d  = load_pos_q + LenW'(1);
          end
        end
        if (in_i.topic_end) begin
          ctl.load_commit = 1'b1;
          sub_cnt_d   = sub_cnt_q + SubW'(1);
          load_pos_d  = '0;
          load_stop_d = 1'b0;
        end
      end
    end else if (acc && b == CHAR_NL) begin
      // Flush a trailing backslash, then the end item.
      item1.data_byte = 8'd0;
      item1.last      = 1'b1;
      case (phase_q)
        PH_MSG:   item1.status = hit_q ? ST_DELIVERED : ST_NO_SUB;
        PH_TOPIC: item1.status = ST_NO_COLON;
        default:  item1.status = ST_NOT_PUB;
      endcase
      if (phase_q == PH_MSG && pend_q && msg_cnt_q < MsgW'(MessageMaxLen - 1)) begin
        push0 = 1'b1;
        push1 = 1'b1;
      end else begin
        item0 = item1;
        push0 = 1'b1;
      end
      line_cnt_d    = '0;
      phase_d       = PH_PREFIX;
      fld_d         = '0;
      ctl.match_set = 1'b1;
      pend_d        = 1'b0;
      msg_cnt_d     = '0;
      ended_d       = 1'b0;
    end else if (acc && !ended_q && line_cnt_q < LineW'(LineMaxLen)) begin
      line_cnt_d = line_cnt_q + LineW'(1);
      if (b == 8'd0) begin
        ended_d = 1'b1;
        if (phase_q == PH_MSG && pend_q) begin
          push0     = 1'b1;
          msg_cnt_d = msg_cnt_q + MsgW'(1);
          pend_d    = 1'b0;
        end
      end else begin
        case (phase_q)
          PH_PREFIX: begin
            if (b == prefix_char(fld_q[1:0])) begin
              fld_d = fld_q + FldW'(1);
              if (fld_q == FldW'(3)) begin
                phase_d       = PH_TOPIC;
                fld_d         = '0;
                ctl.match_set = 1'b1;
              end
            end else begin
              phase_d = PH_BAD;
            end
          end
          PH_TOPIC: begin
            if (b == CHAR_COLON) begin
              hit_d     = hit_chain[MaxTopics];
              sub_idx_d = first_idx;
              phase_d   = PH_MSG;
              msg_cnt_d = '0;
              pend_d    = 1'b0;
            end else if (fld_q < FldW'(TopicMaxLen)) begin
              ctl.cmp_en = 1'b1;
              fld_d      = fld_q + FldW'(1);
            end
          end
          PH_MSG: begin
            if (msg_cnt_q < MsgW'(MessageMaxLen - 1)) begin
              item0.data_byte = b;
              if (!pend_q && b == CHAR_BSL) begin
                pend_d = 1'b1;
              end else begin
                push0     = 1'b1;
                msg_cnt_d = msg_cnt_q + MsgW'(1);
                pend_d    = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      sub_cnt_q   <= '0;
      load_pos_q  <= '0;
      load_stop_q <= 1'b0;
      line_cnt_q  <= '0;
      fld_q       <= '0;
      pend_q      <= 1'b0;
      msg_cnt_q   <= '0;
      hit_q       <= 1'b0;
      sub_idx_q   <= '0;
      ended_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sub_cnt_q   <= sub_cnt_d;
      load_pos_q  <= load_pos_d;
      load_stop_q <= load_stop_d;
      line_cnt_q  <= line_cnt_d;
      fld_q       <= fld_d;
      pend_q      <= pend_d;
      msg_cnt_q   <= msg_cnt_d;
      hit_q       <= hit_d;
      sub_idx_q   <= sub_idx_d;
      ended_q     <= ended_d;
    end
  end

  tlpf_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(push0),
    .push1_i(push1),
    .item0_i(item0),
    .item1_i(item1),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
